@@ rtl/core/tick_driven_task_scheduler_assert.svh @@
// Assertion macros for the task scheduler
`ifndef TICK_DRIVEN_TASK_SCHEDULER_ASSERT_SVH
`define TICK_DRIVEN_TASK_SCHEDULER_ASSERT_SVH
// implication checked every cycle outside reset
`define TDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define TDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

@@ rtl/core/tds_pkg.sv @@
// Shared types and constants for the task scheduler
package tds_pkg;
  localparam int TASK_SLOTS_DEF = 16;
  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRTF = 3'd2;
  localparam logic [2:0] POL_NPP  = 3'd3;
  localparam logic [2:0] POL_PP   = 3'd4;
  localparam logic [2:0] POL_RR   = 3'd5;
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLICE  = 1'b1;
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic start_add;   // latch input and clear scan
    logic start_tick;  // latch input, do rotation, clear scan
    logic scan_step;   // examine one slot
    logic commit_add;
    logic commit_tick_sel; // settle chosen slot
    logic age_step;    // age / update one slot
    logic finish;      // raise out_valid, count time slice down
  } tds_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } tds_stat_t;
endpackage

@@ rtl/core/tds_ctrl.sv @@
// Sequencer for add and tick items
module tds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               func,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tds_pkg::tds_stat_t stat,
  output tds_pkg::tds_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_SEL, S_AGE, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    cmd = '0;
    cmd.start_add  = in_ready && in_valid && (func == tds_pkg::FUNC_ADD);
    cmd.start_tick = in_ready && in_valid && (func == tds_pkg::FUNC_TICK);
    cmd.scan_step  = (state == S_SCAN);
    cmd.commit_tick_sel = (state == S_SEL) && stat.is_tick;
    cmd.commit_add = (state == S_SEL) && !stat.is_tick;
    cmd.age_step   = (state == S_AGE);
    cmd.finish     = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE, S_OUT: begin
          if (in_valid && in_ready) state <= S_SCAN;
          else if (state == S_OUT && out_ready) state <= S_IDLE;
        end
        S_SCAN: if (stat.scan_last) state <= S_DRAIN;
        // last slot read is still being compared
        S_DRAIN: state <= S_SEL;
        S_SEL: state <= stat.is_tick ? S_AGE : S_FIN;
        S_AGE: if (stat.scan_last) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/tds_dp.sv @@
// Task table, slot scan and result registers
module tds_dp #(
  parameter int TASK_SLOTS = tds_pkg::TASK_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tds_pkg::tds_cmd_t  cmd,
  output tds_pkg::tds_stat_t stat,
  input  logic [7:0]         task_id,
  input  logic [7:0]         burst_len,
  input  logic [7:0]         prio_level,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic [7:0]         running_id,
  output logic               finished,
  output logic [7:0]         finished_id,
  output logic [15:0]        finished_wait,
  output logic [15:0]        finished_turnaround,
  output logic               table_full
);
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // packed slot record: id, burst, remaining, prio, wait, order
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  burst;
    logic [7:0]  rem;
    logic [7:0]  prio;
    logic [15:0] wt;
    logic [15:0] order;
  } slot_t;

  slot_t       mem [TASK_SLOTS];
  slot_t       rd;
  logic [TASK_SLOTS-1:0] valid;
  logic [2:0]  policy;
  logic [7:0]  slice_length;
  logic [15:0] order_counter;
  logic        cur_ok;
  logic [SW-1:0] cur;
  logic [7:0]  slice_left;

  logic        is_tick;
  logic [7:0]  in_id, in_burst, in_prio;
  logic [2:0]  pol;
  logic [SW:0] idx;       // scan counter
  logic [SW-1:0] rd_addr;
  logic        rd_live;   // rd holds slot rd_slot
  logic [SW-1:0] rd_slot;
  logic        best_ok;   // best among slots other than the running one
  logic [SW-1:0] best;
  logic [15:0] best_key, best_age;
  logic        cur_seen;
  logic [15:0] cur_key;
  logic        free_ok;
  logic [SW-1:0] free_slot;
  logic        sel_ok;
  logic [SW-1:0] sel;
  logic        keep;
  logic [7:0]  res_run;

  assign stat.is_tick   = is_tick;
  assign stat.scan_last = (idx == (SW+1)'(TASK_SLOTS - 1)) || (idx >= (SW+1)'(TASK_SLOTS));
  assign rd_addr = idx[SW-1:0];

  // key: larger is better
  function automatic logic [15:0] key_of(input slot_t s, input logic [2:0] p,
                                         input logic [15:0] oc);
    logic [15:0] k;
    begin
      unique case (p)
        tds_pkg::POL_SJF:  k = {8'd0, ~s.burst};
        tds_pkg::POL_SRTF: k = {8'd0, ~s.rem};
        tds_pkg::POL_NPP, tds_pkg::POL_PP: k = {8'd0, s.prio};
        default: k = oc - s.order;
      endcase
      return k;
    end
  endfunction

  logic [15:0] rd_key, rd_age;
  assign rd_key = key_of(rd, pol, order_counter);
  assign rd_age = order_counter - rd.order;
  assign keep = cur_ok && (rd_slot == cur);

  always_ff @(posedge clk) begin
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      policy <= tds_pkg::POL_FCFS;
      slice_length <= 8'd4;
      order_counter <= '0;
      cur_ok <= 1'b0;
      cur <= '0;
      slice_left <= '0;
      idx <= '0;
      rd_live <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tds_pkg::REG_POLICY) policy <= cfg_data[2:0];
        else slice_length <= cfg_data;
      end
      rd_live <= cmd.scan_step;
      if (cmd.start_add || cmd.start_tick) begin
        is_tick <= cmd.start_tick;
        in_id <= task_id;
        in_burst <= (burst_len == 8'd0) ? 8'd1 : burst_len;
        in_prio <= prio_level;
        pol <= (policy > tds_pkg::POL_RR) ? tds_pkg::POL_FCFS : policy;
        idx <= '0;
        best_ok <= 1'b0;
        cur_seen <= 1'b0;
        free_ok <= 1'b0;
        if (cmd.start_tick) begin
          if (cur_ok && !valid[cur]) cur_ok <= 1'b0;
          else if (cur_ok && policy == tds_pkg::POL_RR && slice_left == 8'd0) begin
            mem[cur].order <= order_counter;
            order_counter <= order_counter + 16'd1;
            cur_ok <= 1'b0;
          end
        end
      end
      // scan: rd holds slot rd_slot in the cycle after its address
      if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        rd_slot <= rd_addr;
        if (!free_ok && !valid[rd_addr]) begin
          free_ok <= 1'b1; free_slot <= rd_addr;
        end
      end
      // running slot kept apart; it wins ties against the others
      if (rd_live && valid[rd_slot]) begin
        if (keep) begin
          cur_seen <= 1'b1; cur_key <= rd_key;
        end else if (!best_ok || rd_key > best_key ||
                     (rd_key == best_key && rd_age > best_age)) begin
          best_ok <= 1'b1; best <= rd_slot; best_key <= rd_key; best_age <= rd_age;
        end
      end
      if (cmd.commit_add) begin
        res_run <= 8'd0;
        table_full <= !free_ok;
        if (free_ok) begin
          valid[free_slot] <= 1'b1;
          mem[free_slot] <= '{id: in_id, burst: in_burst, rem: in_burst, prio: in_prio,
                              wt: 16'd0, order: order_counter};
          order_counter <= order_counter + 16'd1;
        end
      end
      if (cmd.age_step) begin
        idx <= idx + 1'b1;
        if (valid[rd_addr]) begin
          if (sel_ok && rd_addr == sel) begin
            mem[rd_addr].rem <= mem[rd_addr].rem - 8'd1;
            res_run <= mem[rd_addr].id;
            if (mem[rd_addr].rem == 8'd1) begin
              finished <= 1'b1;
              finished_id <= mem[rd_addr].id;
              finished_wait <= mem[rd_addr].wt;
              finished_turnaround <= ({1'b0, mem[rd_addr].wt} + 17'(mem[rd_addr].burst))
                                     > 17'hFFFF ? 16'hFFFF :
                                     mem[rd_addr].wt + 16'(mem[rd_addr].burst);
              valid[rd_addr] <= 1'b0;
              cur_ok <= 1'b0;
            end
          end else if (mem[rd_addr].wt != 16'hFFFF) begin
            mem[rd_addr].wt <= mem[rd_addr].wt + 16'd1;
          end
        end
      end
      if (cmd.start_add || cmd.start_tick) begin
        finished <= 1'b0; finished_id <= '0; finished_wait <= '0;
        finished_turnaround <= '0; res_run <= '0;
      end
      if (cmd.finish && is_tick && sel_ok && slice_left != 8'd0) slice_left <= slice_left - 8'd1;
      if (cmd.commit_tick_sel) begin
        table_full <= 1'b0;
        idx <= '0;
        // choose running slot
        if (pol == tds_pkg::POL_SRTF || pol == tds_pkg::POL_PP || !cur_ok) begin
          if (cur_seen && !(best_ok && best_key > cur_key)) begin
            sel_ok <= 1'b1; sel <= cur;
          end else begin
            sel_ok <= best_ok; sel <= best;
            cur_ok <= best_ok; cur <= best;
            if (pol == tds_pkg::POL_RR && !cur_ok && best_ok)
              slice_left <= (slice_length == 8'd0) ? 8'd1 : slice_length;
          end
        end else begin
          sel_ok <= 1'b1; sel <= cur;
        end
      end
    end
  end

  assign running_id = res_run;
endmodule

@@ rtl/core/tick_driven_task_scheduler.sv @@
// Top level of the tick-driven task scheduler
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | func task_id burst_len prio_level
//  out     | out_valid/out_ready| running_id finished finished_id wait turnaround table_full
//  cfg     | cfg_we             | cfg_index cfg_data
// An add runs a scan of one slot per cycle, then drain, select, finish
// and the output beat. A tick adds an aging pass of one slot per cycle
// between select and finish. The slot memory has one port.
// Reset clears valid bits and counters; no clearing pass. A stalled
// output holds the result; the next item is taken as it leaves.
module tick_driven_task_scheduler #(
  parameter int TASK_SLOTS = tds_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  task_id,
  input  logic [7:0]  burst_len,
  input  logic [7:0]  prio_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  running_id,
  output logic        finished,
  output logic [7:0]  finished_id,
  output logic [15:0] finished_wait,
  output logic [15:0] finished_turnaround,
  output logic        table_full,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  `include "tick_driven_task_scheduler_assert.svh"

  tds_pkg::tds_cmd_t  cmd;
  tds_pkg::tds_stat_t stat;

  tds_ctrl u_ctrl (
    .clk, .rst, .in_valid, .func, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  tds_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk, .rst, .cmd, .stat, .task_id, .burst_len, .prio_level,
    .cfg_we, .cfg_index, .cfg_data, .running_id, .finished, .finished_id,
    .finished_wait, .finished_turnaround, .table_full
  );

  `TDS_ASSERT_IMP(a_full_no_run, out_valid && table_full, running_id == 8'd0 && !finished)
  `TDS_ASSERT_IMP(a_fin_id, out_valid && finished, finished_id == running_id)
  `TDS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule
